/* rtl/qbb3_pkg.sv */
package qbb3_pkg;

   localparam int unsigned CoordWidth = 16;
   localparam int unsigned Axes = 3;
   localparam int unsigned InvWidth = CoordWidth + 1;
   localparam int unsigned OuterWidth = 20;
   localparam int unsigned MidWidth = 32;
   localparam int unsigned ResultWidth = 32;

   localparam logic signed [InvWidth-1:0] OneFixed = 17'sd4096;
   localparam logic [MidWidth-1:0] MidBias = 32'h0000_8000;

   // Lane 0 is x, lane 1 is y, lane 2 is z.
   typedef logic [Axes-1:0][CoordWidth-1:0] point_type;

   typedef struct packed {
      point_type first;
      point_type mid;
      point_type last;
   } ctrl_points_type;

   typedef struct packed {
      logic signed [OuterWidth-1:0] wa;
      logic [MidWidth-1:0] wb;
      logic signed [OuterWidth-1:0] wc;
   } weights_type;

   typedef struct packed {
      logic enable;
      logic valid;
   } stage_ctrl_type;

endpackage

/* rtl/quadratic_bezier_blend3.sv */
// Channel   Direction  Payload (lowest bits first)
// req_      in         blend_t, first_x/y/z, mid_x/y/z, last_x/y/z (16 bits each)
// rsp_      out        blend_x, blend_y, blend_z (32 bits each)
//
// The pipeline has five register stages, s1 to s5.
// One request is accepted in every cycle while the result side takes its data.
// All stages advance together whenever the output stage is empty or being read.
// A stall holds every stage, and reset clears only the valid bits.
module quadratic_bezier_blend3
   import qbb3_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // blend_t, first_x, first_y, first_z, mid_x, mid_y, mid_z, last_x, last_y, last_z
   input  logic [159:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // blend_x, blend_y, blend_z
   output logic [95:0]  rsp_tdata
);

   stage_ctrl_type                   ctrl_in;
   stage_ctrl_type                   mid_ctrl;
   ctrl_points_type                  req_points;
   ctrl_points_type                  mid_points;
   weights_type                      mid_weights;
   logic                             mid_valid;
   logic                             pipe_enable;
   logic [Axes-1:0][ResultWidth-1:0] blend;

   assign pipe_enable = !rsp_tvalid || rsp_tready;
   assign req_tready  = pipe_enable;

   always_comb begin
      for (int i = 0; i < Axes; i++) begin
         req_points.first[i] = req_tdata[16*(1+i) +: 16];
         req_points.mid[i]   = req_tdata[16*(4+i) +: 16];
         req_points.last[i]  = req_tdata[16*(7+i) +: 16];
      end
      ctrl_in.enable  = pipe_enable;
      ctrl_in.valid   = req_tvalid;
      mid_ctrl.enable = pipe_enable;
      mid_ctrl.valid  = mid_valid;
   end

   qbb3_weights u_weights (
      .clock       (clock),
      .reset       (reset),
      .ctrl_in     (ctrl_in),
      .blend_t     (req_tdata[15:0]),
      .points_in   (req_points),
      .valid_out   (mid_valid),
      .weights_out (mid_weights),
      .points_out  (mid_points)
   );

   qbb3_axis u_axis (
      .clock      (clock),
      .reset      (reset),
      .ctrl_in    (mid_ctrl),
      .weights_in (mid_weights),
      .points_in  (mid_points),
      .valid_out  (rsp_tvalid),
      .blend_out  (blend)
   );

   assign rsp_tdata = {blend[2], blend[1], blend[0]};

endmodule

/* rtl/qbb3_weights.sv */
module qbb3_weights
   import qbb3_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  stage_ctrl_type  ctrl_in,
   input  logic [15:0]     blend_t,
   input  ctrl_points_type points_in,
   output logic            valid_out,
   output weights_type     weights_out,
   output ctrl_points_type points_out
);

   logic                      s1_valid_ff;
   logic signed [15:0]        s1_t_ff;
   logic signed [InvWidth-1:0] s1_inv_ff;
   logic signed [InvWidth-1:0] s1_inv_in;
   ctrl_points_type           s1_points_ff;

   logic                      s2_valid_ff;
   logic signed [33:0]        s2_aa_full;
   logic signed [32:0]        s2_ab_full;
   logic signed [31:0]        s2_cc_full;
   logic signed [19:0]        s2_aa_ff;
   logic signed [23:0]        s2_ab_ff;
   logic signed [19:0]        s2_cc_ff;
   ctrl_points_type           s2_points_ff;

   logic                      s3_valid_ff;
   weights_type               s3_weights_ff;
   weights_type               s3_weights_in;
   ctrl_points_type           s3_points_ff;

   assign s1_inv_in = OneFixed - {blend_t[15], blend_t};

   assign s2_aa_full = s1_inv_ff * s1_inv_ff;
   assign s2_ab_full = s1_inv_ff * s1_t_ff;
   assign s2_cc_full = s1_t_ff * s1_t_ff;

   // For wa and wc, the shift left by three and right by twelve keeps product bits 28 to 9; wb keeps bits 31 to 8.
   always_comb begin
      s3_weights_in.wa = s2_aa_ff;
      s3_weights_in.wb = {{8{s2_ab_ff[23]}}, s2_ab_ff} + MidBias;
      s3_weights_in.wc = s2_cc_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else if (ctrl_in.enable) begin
         s1_valid_ff <= ctrl_in.valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl_in.enable) begin
         s1_t_ff       <= blend_t;
         s1_inv_ff     <= s1_inv_in;
         s1_points_ff  <= points_in;
         s2_aa_ff      <= s2_aa_full[28:9];
         s2_ab_ff      <= s2_ab_full[31:8];
         s2_cc_ff      <= s2_cc_full[28:9];
         s2_points_ff  <= s1_points_ff;
         s3_weights_ff <= s3_weights_in;
         s3_points_ff  <= s2_points_ff;
      end
   end

   assign valid_out   = s3_valid_ff;
   assign weights_out = s3_weights_ff;
   assign points_out  = s3_points_ff;

endmodule

/* rtl/qbb3_axis.sv */
module qbb3_axis
   import qbb3_pkg::*;
(
   input  logic                              clock,
   input  logic                              reset,
   input  stage_ctrl_type                    ctrl_in,
   input  weights_type                       weights_in,
   input  ctrl_points_type                   points_in,
   output logic                              valid_out,
   output logic [Axes-1:0][ResultWidth-1:0]  blend_out
);

   logic                     s4_valid_ff;
   logic signed [35:0]       s4_pa_full [Axes];
   logic signed [35:0]       s4_pc_full [Axes];
   logic [31:0]              s4_pb_in   [Axes];
   logic [31:0]              s4_pa_ff   [Axes];
   logic [31:0]              s4_pb_ff   [Axes];
   logic [31:0]              s4_pc_ff   [Axes];

   logic                     s5_valid_ff;
   logic [Axes-1:0][31:0]    s5_sum_in;
   logic [Axes-1:0][31:0]    s5_sum_ff;

   always_comb begin
      for (int i = 0; i < Axes; i++) begin
         s4_pa_full[i] = $signed(points_in.first[i]) * weights_in.wa;
         s4_pb_in[i]   = {{16{points_in.mid[i][15]}}, points_in.mid[i]} * weights_in.wb;
         s4_pc_full[i] = $signed(points_in.last[i]) * weights_in.wc;
         s5_sum_in[i]  = s4_pa_ff[i] + s4_pb_ff[i] + s4_pc_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
      end else if (ctrl_in.enable) begin
         s4_valid_ff <= ctrl_in.valid;
         s5_valid_ff <= s4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl_in.enable) begin
         for (int i = 0; i < Axes; i++) begin
            s4_pa_ff[i] <= s4_pa_full[i][31:0];
            s4_pb_ff[i] <= s4_pb_in[i];
            s4_pc_ff[i] <= s4_pc_full[i][31:0];
         end
         s5_sum_ff <= s5_sum_in;
      end
   end

   assign valid_out = s5_valid_ff;
   assign blend_out = s5_sum_ff;

endmodule

/* tb/blend_checker.sv */
`timescale 1ns / 1ps

module blend_checker
   import qbb3_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   // blend_t, first_x, first_y, first_z, mid_x, mid_y, mid_z, last_x, last_y, last_z
   input  logic [159:0] req_tdata,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   // blend_x, blend_y, blend_z
   input  logic [95:0]  rsp_tdata,
   output int           mismatch_count,
   output int           outstanding
);

   logic [95:0] expected_blends[$];

   function automatic logic [31:0] widen_coord(logic [CoordWidth-1:0] coord);
      return {{(32 - CoordWidth){coord[CoordWidth-1]}}, coord};
   endfunction

   // Every product and sum is kept to 32 bits, so the blend wraps like the hardware.
   function automatic logic [95:0] bezier_blend(logic [159:0] request);
      logic [31:0] t;
      logic [31:0] inv;
      logic [31:0] prod;
      logic signed [31:0] scaled;
      logic [31:0] wa;
      logic [31:0] wb;
      logic [31:0] wc;
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] c;
      logic [31:0] sum;
      logic [95:0] blended;
      int axis;
      t = widen_coord(request[15:0]);
      inv = 32'd4096 - t;
      prod = inv * inv;
      prod = prod << 3;
      scaled = prod;
      wa = scaled >>> 12;
      prod = inv * t;
      scaled = prod;
      wb = scaled >>> 8;
      wb = wb + MidBias;
      prod = t * t;
      prod = prod << 3;
      scaled = prod;
      wc = scaled >>> 12;
      for (axis = 0; axis < Axes; axis++) begin
         a = widen_coord(request[16 + 16 * axis +: 16]);
         b = widen_coord(request[64 + 16 * axis +: 16]);
         c = widen_coord(request[112 + 16 * axis +: 16]);
         sum = a * wa + b * wb + c * wc;
         blended[32 * axis +: 32] = sum;
      end
      return blended;
   endfunction

   always @(posedge clock) begin
      logic [95:0] expected;
      string axis_name[3];
      axis_name = '{"blend_x", "blend_y", "blend_z"};
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_blends.size() == 0) begin
               $error("unexpected result %h with no request outstanding", rsp_tdata);
               mismatch_count++;
            end else begin
               expected = expected_blends.pop_front();
               for (int axis = 0; axis < Axes; axis++) begin
                  if (rsp_tdata[32 * axis +: 32] !== expected[32 * axis +: 32]) begin
                     $error("%s mismatch: expected %h, actual %h", axis_name[axis],
                            expected[32 * axis +: 32], rsp_tdata[32 * axis +: 32]);
                     mismatch_count++;
                  end
               end
            end
         end
         if (req_tvalid && req_tready) begin
            expected_blends.push_back(bezier_blend(req_tdata));
         end
         outstanding = expected_blends.size();
      end
   end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps

module testbench;

   localparam int StallLimit = 2000;
   localparam int RandomRequests = 450;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [159:0] req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [95:0]  rsp_tdata;
   int           mismatch_count;
   int           outstanding;
   int           stuck_cycles = 0;
   bit           idle_enable = 1'b1;

   quadratic_bezier_blend3 uut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata)
   );

   blend_checker u_checker (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .mismatch_count(mismatch_count),
      .outstanding(outstanding)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      rsp_tready <= !idle_enable || ($urandom_range(0, 99) >= 6);
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stuck_cycles <= 0;
      end else if (stuck_cycles >= StallLimit) begin
         $display("Test completed with failures");
         $finish;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   function automatic logic [15:0] corner_value(int unsigned pick);
      case (pick % 4)
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'h0000;
         default: return 16'hFFFF;
      endcase
   endfunction

   function automatic logic [15:0] random_blend();
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return 16'($urandom_range(0, 4096));
         4: return corner_value($urandom_range(0, 3));
         5: return 16'($urandom_range(4096 - 16, 4096 + 16));
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [15:0] random_coord();
      if ($urandom_range(0, 7) == 0) begin
         return corner_value($urandom_range(0, 3));
      end
      return 16'($urandom);
   endfunction

   task automatic send_request(logic [159:0] payload);
      if (idle_enable && $urandom_range(0, 99) < 6) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= payload;
      do @(posedge clock); while (!req_tready);
   endtask

   initial begin
      logic [15:0] blend_values[12];
      logic [159:0] payload;
      blend_values = '{16'd0, 16'd4096, 16'd2048, 16'h8000, 16'h7FFF, 16'hFFFF,
                       16'd1, 16'd4095, 16'd4097, 16'd8192, 16'd1024, 16'hF000};
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Corner values of the blend parameter, each with two patterns of extreme coordinates.
      for (int i = 0; i < 12; i++) begin
         for (int j = 0; j < 2; j++) begin
            payload[15:0] = blend_values[i];
            for (int k = 1; k < 10; k++) begin
               payload[16 * k +: 16] = corner_value(i + k + 2 * j);
            end
            send_request(payload);
         end
      end

      for (int n = 0; n < RandomRequests; n++) begin
         idle_enable = !(n >= 150 && n < 300);
         payload[15:0] = random_blend();
         for (int k = 1; k < 10; k++) begin
            payload[16 * k +: 16] = random_coord();
         end
         send_request(payload);
      end
      idle_enable = 1'b1;
      req_tvalid <= 1'b0;

      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatch_count == 0 && outstanding == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

/* files.f */
rtl/qbb3_pkg.sv
rtl/qbb3_weights.sv
rtl/qbb3_axis.sv
rtl/quadratic_bezier_blend3.sv
tb/blend_checker.sv
tb/testbench.sv
